/* src/phsc_pkg.sv */
// Package for the probing hash sample counter.
// Holds the beat types, action and status codes and the control state type.
// No dependencies.
package phsc_pkg;

   localparam int KEY_W   = 64;
   localparam int COUNT_W = 64;
   localparam int SLOT_W  = 9;
   localparam int LEVEL_W = 8;
   localparam int DIGIT_W = 8;

   localparam logic [2:0] ACT_SAMPLE  = 3'd0;
   localparam logic [2:0] ACT_CLEAR   = 3'd1;
   localparam logic [2:0] ACT_SUSPEND = 3'd2;
   localparam logic [2:0] ACT_RESUME  = 3'd3;
   localparam logic [2:0] ACT_READ    = 3'd4;

   localparam logic [2:0] STAT_COUNTED   = 3'd0;
   localparam logic [2:0] STAT_SUSPENDED = 3'd1;
   localparam logic [2:0] STAT_ZERO      = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_DONE      = 3'd4;
   localparam logic [2:0] STAT_UNDERFLOW = 3'd5;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

   typedef struct packed {
      logic [2:0]         action;
      logic [KEY_W-1:0]   sample_state;
      logic [SLOT_W-1:0]  entry_index;
   } phsc_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [SLOT_W-1:0]  slot;
      logic [KEY_W-1:0]   entry_state;
      logic [COUNT_W-1:0] entry_count;
      logic [LEVEL_W-1:0] suspend_level;
   } phsc_rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_READ,
      S_CHECK,
      S_RESP
   } phsc_state_type;

endpackage

/* src/phsc_mod.sv */
// Remainder of a 64-bit key by the table size, one byte per cycle.
// Depends on phsc_pkg.
module phsc_mod
   import phsc_pkg::*;
#(
   parameter int TABLE_SIZE = 257
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_W-1:0]              value,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] remainder
);

   localparam int AW    = $clog2(TABLE_SIZE);
   localparam int STEPS = KEY_W / DIGIT_W;
   localparam int CW    = $clog2(STEPS);
   localparam logic [AW:0]   NX   = (AW+1)'(TABLE_SIZE);
   localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

   logic [KEY_W-1:0] shift_ff, shift_in;
   logic [AW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AW-1:0]    rem_step;

   always_comb begin
      logic [AW-1:0] r;
      logic [AW:0]   t;
      r = rem_ff;
      t = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         t = {r, shift_ff[KEY_W-1-i]};
         if (t >= NX) begin
            t = t - NX;
         end
         r = t[AW-1:0];
      end
      rem_step = r;
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = value;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << DIGIT_W;
         rem_in   = rem_step;
         cnt_in   = cnt_ff + CW'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* src/probing_hash_sample_counter.sv */
// A sample runs the remainder unit, then one memory read and one check per probed
// slot; an in-range read does one memory read and one check; a clear runs a clearing
// pass; other beats go straight to the response.
// Throughput: one beat at a time; a new beat is taken while the last result waits.
// Reset: a clearing pass zeroes all TABLE_SIZE slots (257 by default), one slot per
// cycle; no beat is taken until it ends. Depends on phsc_pkg and phsc_mod.
module probing_hash_sample_counter
   import phsc_pkg::*;
#(
   parameter int TABLE_SIZE = 257
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  phsc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output phsc_rsp_type rsp_data
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int TW = $clog2(TABLE_SIZE + 1);
   localparam int EW = KEY_W + COUNT_W;
   localparam logic [AW-1:0] POS_LAST = AW'(TABLE_SIZE - 1);
   localparam logic [TW-1:0] TRY_LAST = TW'(TABLE_SIZE - 1);

   phsc_state_type    state_ff, state_in;
   logic [2:0]        act_ff, act_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [TW-1:0]     tries_ff, tries_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [LEVEL_W-1:0] depth_ff, depth_in;
   phsc_rsp_type      res_ff, res_in;
   phsc_rsp_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [EW-1:0]     mem [TABLE_SIZE];
   logic [EW-1:0]     rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [EW-1:0]     mem_wdata;

   logic              mod_start;
   logic              mod_done;
   logic [AW-1:0]     mod_rem;

   logic [KEY_W-1:0]   rd_key;
   logic [COUNT_W-1:0] rd_count;
   logic               hit;
   logic               clr_last;
   logic               accept;
   logic               load_out;
   logic               read_ok;

   assign rd_key   = rd_data_ff[EW-1:COUNT_W];
   assign rd_count = rd_data_ff[COUNT_W-1:0];
   assign hit      = (rd_key == key_ff) || (rd_key == '0);
   assign clr_last = clr_cnt_ff == POS_LAST;
   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign load_out = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign read_ok  = 32'(req_data.entry_index) < 32'(TABLE_SIZE);

   phsc_mod #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .value     (req_data.sample_state),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = clr_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.action)
                  ACT_SAMPLE: begin
                     if (depth_ff == '0 && req_data.sample_state != '0) begin
                        state_in = S_MOD;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  ACT_CLEAR: state_in = S_CLEAR;
                  ACT_READ:  state_in = read_ok ? S_READ : S_RESP;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_MOD: begin
            if (mod_done) begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (act_ff == ACT_READ || hit || tries_ff == TRY_LAST) begin
               state_in = S_RESP;
            end else begin
               state_in = S_READ;
            end
         end
         S_RESP: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      act_in       = act_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      tries_in     = tries_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      depth_in     = depth_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = {key_ff, rd_count + COUNT_W'(1)};
      mod_start    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_last) begin
               clr_rsp_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in = req_data.action;
               key_in = req_data.sample_state;
               res_in = '0;
               res_in.status = STAT_DONE;
               unique case (req_data.action)
                  ACT_SAMPLE: begin
                     if (depth_ff != '0) begin
                        res_in.status = STAT_SUSPENDED;
                     end else if (req_data.sample_state == '0) begin
                        res_in.status = STAT_ZERO;
                     end else begin
                        mod_start = 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  ACT_SUSPEND: begin
                     if (depth_ff != LEVEL_MAX) begin
                        depth_in = depth_ff + LEVEL_W'(1);
                     end
                  end
                  ACT_RESUME: begin
                     if (depth_ff == '0) begin
                        res_in.status = STAT_UNDERFLOW;
                     end else begin
                        depth_in = depth_ff - LEVEL_W'(1);
                     end
                  end
                  ACT_READ: begin
                     res_in.slot = req_data.entry_index;
                     pos_in      = AW'(req_data.entry_index);
                  end
                  default: ;
               endcase
            end
         end
         S_MOD: begin
            if (mod_done) begin
               pos_in   = mod_rem;
               tries_in = '0;
            end
         end
         S_READ: ;
         S_CHECK: begin
            if (act_ff == ACT_READ) begin
               res_in.entry_state = rd_key;
               res_in.entry_count = rd_count;
            end else if (hit) begin
               mem_we             = 1'b1;
               res_in.status      = STAT_COUNTED;
               res_in.slot        = SLOT_W'(pos_ff);
               res_in.entry_state = key_ff;
               res_in.entry_count = rd_count + COUNT_W'(1);
            end else if (tries_ff == TRY_LAST) begin
               res_in.status = STAT_FULL;
            end else begin
               tries_in = tries_ff + TW'(1);
               pos_in   = (pos_ff == POS_LAST) ? '0 : pos_ff + AW'(1);
            end
         end
         S_RESP: begin
            if (load_out) begin
               rsp_in               = res_ff;
               rsp_in.suspend_level = depth_ff;
               rsp_valid_in         = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      tries_ff <= tries_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
